// File: design/bounded_list_insert_delete_dump_macros.svh
// ----------------------------------------------------------------------------
// Bounded list assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_INSERT_DELETE_DUMP_MACROS_SVH
`define BOUNDED_LIST_INSERT_DELETE_DUMP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BLDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BLDD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BLDD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bldd_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list package
// Sizes, operation codes and the command bundle to the element ring.
// ----------------------------------------------------------------------------
package bldd_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int POS_W    = 8;
  localparam int EIDX_W   = 6;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2
  } op_e;

  // Logical indexes are relative to the front of the list.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;
    logic              head_dec;
  } ring_cmd_t;

endpackage

// File: design/bldd_in_if.sv
// ----------------------------------------------------------------------------
// Bounded list operation channel
// Valid/ready channel carrying one list operation per transfer.
// ----------------------------------------------------------------------------
interface bldd_in_if import bldd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// File: design/bldd_out_if.sv
// ----------------------------------------------------------------------------
// Bounded list dump channel
// Valid/ready channel carrying one dumped list element per transfer.
// ----------------------------------------------------------------------------
interface bldd_out_if import bldd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] elem_value;
  logic [EIDX_W-1:0]        elem_index;
  logic                     last;
  logic                     list_empty;
  logic                     insert_dropped;

  modport source (output valid, output elem_value, output elem_index, output last,
                  output list_empty, output insert_dropped, input ready);
  modport sink   (input valid, input elem_value, input elem_index, input last,
                  input list_empty, input insert_dropped, output ready);
endinterface

// File: design/bldd_ring.sv
// ----------------------------------------------------------------------------
// Bounded list element ring
// Circular element memory with a head pointer; maps logical to physical slots.
// ----------------------------------------------------------------------------
module bldd_ring import bldd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_cmd_t         cmd_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [IDX_W-1:0]  head_q, head_d;
  logic [DATA_W-1:0] mem_q [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_phys, wr_phys;

  // Add the head offset and wrap once around the ring.
  function automatic logic [IDX_W-1:0] to_phys(logic [IDX_W-1:0] head,
                                               logic [IDX_W-1:0] lidx);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign rd_phys = to_phys(head_q, cmd_i.rd_idx);
  assign wr_phys = to_phys(head_q, cmd_i.wr_idx);

  // Step the head back one slot on a front insert.
  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_phys] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_phys];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/bounded_list_insert_delete_dump.sv
// ----------------------------------------------------------------------------
// Bounded list with insert, delete and dump
// Ordered list of signed 32-bit values; every operation dumps the whole list.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake     | Payload
//  --------+-----+---------------+----------------------------------------------
//  in_i    | in  | valid / ready | op, value, position
//  out_o   | out | valid / ready | elem_value, elem_index, last, list_empty,
//          |     |               | insert_dropped
//
// Sequence: ST_IDLE takes the operation; a delete that lands then moves each
// later element down a slot (count - position - 1 of them, ST_SHIFT_RD then
// ST_SHIFT_WR) and closes the gap; ST_DUMP_RD and ST_DUMP_LD then dump every
// element (one flagged result when empty), all via the ring's single port pair.
// Reset: rst_ni clears the count, head pointer and sequencer; the element
// memory needs no clearing since only slots below the count are ever read.
// Stalls: a dump read is issued only when the output register is free or is
// being transferred this cycle; in_i is ready only between operations.
// ----------------------------------------------------------------------------
`include "bounded_list_insert_delete_dump_macros.svh"

module bounded_list_insert_delete_dump import bldd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bldd_in_if.sink    in_i,
  bldd_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DUMP_RD,
    ST_DUMP_LD
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  cur_q;
  logic [CNT_W-1:0]  cur_nxt;
  logic              dropped_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  logic [EIDX_W-1:0] out_index_q;
  logic              out_last_q;
  logic              out_empty_q;
  logic              out_dropped_q;

  ring_cmd_t         cmd;
  logic [DATA_W-1:0] rd_data;

  logic in_xfer;
  logic out_free;
  logic out_load;
  logic full;
  logic is_insert;
  logic del_hit;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  // Load the output register with the empty marker or with a fetched element.
  assign out_load   = ((state_q == ST_DUMP_RD) && out_free && (count_q == '0)) ||
                      (state_q == ST_DUMP_LD);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign is_insert  = (in_i.op == OP_PUSH_FRONT) || (in_i.op == OP_PUSH_BACK);
  // Delete lands only when the position is below the current count.
  assign del_hit    = (in_i.op == OP_DELETE) && (in_i.position < POS_W'(count_q));
  assign cur_nxt    = cur_q + CNT_W'(1);

  // Ring commands: insert write on accept, shift read/write pairs, dump reads.
  always_comb begin
    cmd = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_insert && !full) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_data = in_i.value;
          if (in_i.op == OP_PUSH_FRONT) begin
            // One slot before the front wraps to head minus one.
            cmd.wr_idx   = IDX_W'(CAPACITY - 1);
            cmd.head_dec = 1'b1;
          end else begin
            cmd.wr_idx = IDX_W'(count_q);
          end
        end
      end
      ST_SHIFT_RD: begin
        if (cur_nxt < count_q) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = IDX_W'(cur_nxt);
        end
      end
      ST_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_idx  = IDX_W'(cur_q);
        cmd.wr_data = rd_data;
      end
      ST_DUMP_RD: begin
        if (out_free && (count_q != '0)) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = IDX_W'(cur_q);
        end
      end
      default: ;
    endcase
  end

  bldd_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );

  // Sequencer, count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      cur_q         <= '0;
      dropped_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_value_q   <= '0;
      out_index_q   <= '0;
      out_last_q    <= 1'b0;
      out_empty_q   <= 1'b0;
      out_dropped_q <= 1'b0;
    end else begin
      // Raise valid on a load; otherwise retire the held result once taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            dropped_q <= is_insert && full;
            cur_q     <= '0;
            state_q   <= ST_DUMP_RD;
            if (is_insert && !full) begin
              count_q <= count_q + CNT_W'(1);
            end else if (del_hit) begin
              cur_q   <= CNT_W'(in_i.position);
              state_q <= ST_SHIFT_RD;
            end
          end
        end
        ST_SHIFT_RD: begin
          if (cur_nxt < count_q) begin
            state_q <= ST_SHIFT_WR;
          end else begin
            // Tail reached: drop the last slot and start the dump.
            count_q <= count_q - CNT_W'(1);
            cur_q   <= '0;
            state_q <= ST_DUMP_RD;
          end
        end
        ST_SHIFT_WR: begin
          cur_q   <= cur_nxt;
          state_q <= ST_SHIFT_RD;
        end
        ST_DUMP_RD: begin
          if (out_free) begin
            if (count_q == '0) begin
              // Empty list: a single flagged result, no memory read.
              out_value_q   <= '0;
              out_index_q   <= '0;
              out_last_q    <= 1'b1;
              out_empty_q   <= 1'b1;
              out_dropped_q <= dropped_q;
              state_q       <= ST_IDLE;
            end else begin
              state_q <= ST_DUMP_LD;
            end
          end
        end
        ST_DUMP_LD: begin
          out_value_q   <= rd_data;
          out_index_q   <= EIDX_W'(cur_q);
          out_last_q    <= (cur_nxt == count_q);
          out_empty_q   <= 1'b0;
          out_dropped_q <= dropped_q;
          cur_q         <= cur_nxt;
          state_q       <= (cur_nxt == count_q) ? ST_IDLE : ST_DUMP_RD;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.elem_value     = out_value_q;
  assign out_o.elem_index     = out_index_q;
  assign out_o.last           = out_last_q;
  assign out_o.list_empty     = out_empty_q;
  assign out_o.insert_dropped = out_dropped_q;

  // Assertions
  `BLDD_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "element count above capacity")
  `BLDD_ASSERT_IMP(a_empty_shape, out_valid_q && out_empty_q, out_last_q && (out_index_q == '0) && (out_value_q == '0), "empty result malformed")
  `BLDD_ASSERT_NXT(a_insert_count, in_xfer && is_insert && !full, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")

endmodule

// File: tb/sv/tb_bounded_list_insert_delete_dump.sv
// ----------------------------------------------------------------------------
// Bounded list testbench
// Drives list operations through the valid/ready operation channel, keeps a
// behavioral copy of the list, and checks each dumped element in order.
// ----------------------------------------------------------------------------
module tb_bounded_list_insert_delete_dump import bldd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth op code has no meaning; the block must dump the list unchanged.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 10;
  localparam int ITEM_TARGET  = 210;
  // No idling on either side once this few items remain to be taken.
  localparam int TAIL_ITEMS   = 30;
  // Covers a full delete shift plus a full dump after the last result.
  localparam int SETTLE_CYCLES = 160;
  localparam longint TIMEOUT_NS = 8_000_000;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } list_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [EIDX_W-1:0]        index;
    logic                     last;
    logic                     empty;
    logic                     dropped;
  } elem_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bldd_in_if  in_if ();
  bldd_out_if out_if ();

  bounded_list_insert_delete_dump uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  list_op_t pending[$];        // operations not yet offered to the block
  list_op_t next_op;
  logic signed [DATA_W-1:0] list_model[$];  // predicted list, front first
  elem_t    dump_q[$];         // expected dump elements, oldest first
  elem_t    got_elem;
  logic     got_valid;

  int total_items  = 0;
  int accepted_cnt = 0;
  int plan_count   = 0;        // list size as the stimulus plan sees it
  int in_gap       = 0;
  int out_gap      = 0;
  int errors       = 0;
  logic quiet;

  assign quiet = (accepted_cnt >= total_items - TAIL_ITEMS);

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Apply one accepted operation to the list copy and queue the full dump it
  // causes. A dropped insert flags every element of that dump.
  task automatic apply_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                          input logic [POS_W-1:0] pos);
    elem_t e;
    logic  dropped;
    int    n;
    dropped = 1'b0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_model.size() >= CAPACITY) begin
          dropped = 1'b1;
        end else if (op == OP_PUSH_FRONT) begin
          list_model.push_front(value);
        end else begin
          list_model.push_back(value);
        end
      end
      OP_DELETE: begin
        // Out-of-range positions are ignored; otherwise close the gap.
        if (int'(pos) < list_model.size()) begin
          for (int i = int'(pos); i + 1 < list_model.size(); i++) begin
            list_model[i] = list_model[i + 1];
          end
          void'(list_model.pop_back());
        end
      end
      default: ;
    endcase
    n = list_model.size();
    if (n == 0) begin
      e.value = '0; e.index = '0; e.last = 1'b1; e.empty = 1'b1; e.dropped = dropped;
      dump_q.push_back(e);
    end else begin
      for (int i = 0; i < n; i++) begin
        e.value   = list_model[i];
        e.index   = EIDX_W'(i);
        e.last    = (i == n - 1);
        e.empty   = 1'b0;
        e.dropped = dropped;
        dump_q.push_back(e);
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [DATA_W-1:0] got,
                           input logic [DATA_W-1:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  task automatic check_elem(input elem_t got);
    elem_t want;
    if (dump_q.size() == 0) begin
      report($sformatf("unexpected element value %0h index %0d", got.value, got.index));
    end else begin
      want = dump_q.pop_front();
      cmp_field("elem_value", got.value, want.value);
      cmp_field("elem_index", DATA_W'(got.index), DATA_W'(want.index));
      cmp_field("last", DATA_W'(got.last), DATA_W'(want.last));
      cmp_field("list_empty", DATA_W'(got.empty), DATA_W'(want.empty));
      cmp_field("insert_dropped", DATA_W'(got.dropped), DATA_W'(want.dropped));
    end
  endtask

  // Queue one operation and track the list size it leads to, so later
  // deletes can aim at positions that exist.
  task automatic add_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                        input logic [POS_W-1:0] pos);
    list_op_t t;
    t.op = op; t.value = value; t.position = pos;
    pending.push_back(t);
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && plan_count < CAPACITY) begin
      plan_count++;
    end else if (op == OP_DELETE && int'(pos) < plan_count) begin
      plan_count--;
    end
  endtask

  // Random operation: push_pct percent inserts, a few unused codes, the rest
  // deletes. Most delete positions hit the list; the rest span all 8 bits.
  task automatic add_random(input int push_pct);
    int roll;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(0, 99);
    if (plan_count > 0 && $urandom_range(0, 4) != 0) begin
      pos = POS_W'($urandom_range(0, plan_count - 1));
    end else begin
      pos = POS_W'($urandom_range(0, 255));
    end
    if (roll < push_pct) begin
      add_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, pos);
    end else if (roll < 96) begin
      add_op(OP_DELETE, $urandom, pos);
    end else begin
      add_op(OP_UNUSED, $urandom, pos);
    end
  endtask

  // Driver: hold an offered operation until its transfer, then advance to
  // the next one or insert an idle burst.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.op       <= OP_PUSH_FRONT;
      in_if.value    <= '0;
      in_if.position <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_op(in_if.op, in_if.value, in_if.position);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 18);
          in_if.valid <= 1'b0;
        end else begin
          next_op = pending.pop_front();
          in_if.valid    <= 1'b1;
          in_if.op       <= next_op.op;
          in_if.value    <= next_op.value;
          in_if.position <= next_op.position;
        end
      end
    end
  end

  // Monitor: stall the dump in random bursts and capture each transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      got_valid    <= 1'b0;
    end else begin
      got_valid        <= out_if.valid && out_if.ready;
      got_elem.value   <= out_if.elem_value;
      got_elem.index   <= out_if.elem_index;
      got_elem.last    <= out_if.last;
      got_elem.empty   <= out_if.list_empty;
      got_elem.dropped <= out_if.insert_dropped;
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 18);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare on the falling edge, after the driver has queued its prediction.
  always @(negedge clk_i) begin
    if (got_valid) begin
      check_elem(got_elem);
    end
  end

  initial begin
    int floor_cnt;
    rst_ni = 1'b0;

    // Directed: empty dumps, value extremes, ignored deletes, deletes at the
    // middle, back and front, and removal of the only element.
    add_op(OP_DELETE, 32'sh1234_5678, 8'd0);
    add_op(OP_UNUSED, 32'sh0, 8'd0);
    add_op(OP_PUSH_BACK, 32'sh7FFF_FFFF, 8'd0);
    add_op(OP_PUSH_FRONT, 32'sh8000_0000, 8'd255);
    add_op(OP_PUSH_BACK, 32'sh0, 8'd0);
    add_op(OP_PUSH_FRONT, -32'sd1, 8'd0);
    add_op(OP_DELETE, 32'sh0, 8'd255);
    add_op(OP_DELETE, 32'sh0, 8'd4);
    add_op(OP_UNUSED, 32'sh5555_AAAA, 8'd1);
    add_op(OP_DELETE, 32'sh0, 8'd1);
    add_op(OP_DELETE, 32'sh0, 8'd2);
    add_op(OP_DELETE, 32'sh0, 8'd0);
    add_op(OP_DELETE, -32'sd1, 8'd0);
    add_op(OP_PUSH_FRONT, 32'shA5A5_A5A5, 8'd128);
    add_op(OP_DELETE, 32'sh0, 8'd0);
    add_op(OP_PUSH_BACK, 32'sh5A5A_5A5A, 8'd0);
    add_op(OP_DELETE, 32'sh0, 8'd1);

    // Random rounds: fill to capacity, push into the full list, mix, then
    // drain to a few elements.
    while (pending.size() < ITEM_TARGET) begin
      while (plan_count < CAPACITY) add_random(85);
      repeat ($urandom_range(2, 4)) add_random(100);
      repeat (12) add_random(50);
      floor_cnt = $urandom_range(0, 3);
      while (plan_count > floor_cnt) add_random(15);
    end
    // Trim the last round back to the target count.
    while (pending.size() > ITEM_TARGET) void'(pending.pop_back());
    total_items = pending.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_items) @(posedge clk_i);
    while (dump_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
